/* rtl/core/s256bc_pkg.sv */
// Shared types, constants and mixing functions for the SHA-256 compression block.
// Used by sha256_block_compression; no dependencies.
`default_nettype none
package s256bc_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned HASH_N   = 8;
    localparam int unsigned BLOCK_N  = 16;
    localparam int unsigned ROUNDS   = 64;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_LOAD,
        ST_ROUND,
        ST_WBACK
    } t_state;

    localparam t_word ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word HASH_IV [HASH_N] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word f_big0(input t_word x);
        f_big0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word f_big1(input t_word x);
        f_big1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word f_sml0(input t_word x);
        f_sml0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word f_sml1(input t_word x);
        f_sml1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage
`default_nettype wire

/* rtl/core/s256bc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module s256bc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* rtl/core/sha256_block_compression.sv */
// SHA-256 block compression top level: message window, round datapath, control.
// Depends on s256bc_pkg and s256bc_ram (hash state memory).
//
// Input channel: one 32-bit word of a padded block per transfer, with a start
// flag that restarts the chain from the initial hash values; words are taken
// one per cycle while the block gathers a block of sixteen.
// Output channel: one transfer of eight digest words after every sixteenth word.
// Compression: after the sixteenth word the block reads the hash memory, runs
// the rounds one after another, and adds and writes the state back; then the
// digest appears in the output register. Words of the next block are not taken
// until the write-back ends; the round loop and the single read port of the hash
// memory set the block rate.
// Stall: the digest is held in the output register while the receiver stalls;
// the next block's words are still taken, but its compression waits until the
// digest transfer completes.
// Reset: the hash state reads as the initial values (no clearing pass), the
// word count is zero and no digest is pending.
`default_nettype none
module sha256_block_compression (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output      logic                o_stall,
    input  wire s256bc_pkg::t_word   i_message_word,
    input  wire logic                i_start_message,
    output      logic                o_valid,
    input  wire logic                i_stall,
    output      s256bc_pkg::t_word   o_digest_word0,
    output      s256bc_pkg::t_word   o_digest_word1,
    output      s256bc_pkg::t_word   o_digest_word2,
    output      s256bc_pkg::t_word   o_digest_word3,
    output      s256bc_pkg::t_word   o_digest_word4,
    output      s256bc_pkg::t_word   o_digest_word5,
    output      s256bc_pkg::t_word   o_digest_word6,
    output      s256bc_pkg::t_word   o_digest_word7
);
    import s256bc_pkg::*;

    t_state     r_state, n_state;
    logic [3:0] r_wcnt, n_wcnt;
    logic [5:0] r_cnt, n_cnt;
    logic       r_iv_sel, n_iv_sel;
    logic       r_out_valid, n_out_valid;
    logic       r_rd_v;
    logic [2:0] r_rd_idx;
    t_word      r_v [HASH_N];
    t_word      n_v [HASH_N];
    t_word      r_w [BLOCK_N];
    t_word      n_w [BLOCK_N];

    logic       in_xfer, out_xfer, rd_en, ram_we;
    logic [2:0] ram_raddr;
    t_word      ram_rdata, hash_word, sum_word, wb_word;
    t_word      t1, t2, w_new;

    s256bc_ram #(.WIDTH(WORD_W), .DEPTH(HASH_N)) u_hash_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_rd_idx),
        .i_wdata (sum_word),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_out_valid && !i_stall;

    // hash word: initial values until the first write-back after a restart
    assign hash_word = r_iv_sel ? HASH_IV[r_rd_idx] : ram_rdata;
    assign sum_word  = hash_word + r_v[0];

    // round terms and schedule expansion
    assign t1 = r_v[7] + f_big1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + ROUND_K[r_cnt] + r_w[0];
    assign t2 = f_big0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign w_new = r_w[0] + f_sml0(r_w[1]) + r_w[9] + f_sml1(r_w[14]);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_COLLECT: begin
                if (in_xfer && (i_start_message || r_wcnt == 4'd15)) begin
                    if (i_start_message) n_state = ST_COLLECT;
                    if (!i_start_message) n_state = ST_LOAD;
                end
            end
            ST_LOAD:  if (r_rd_v && r_rd_idx == 3'd7) n_state = ST_ROUND;
            ST_ROUND: if (r_cnt == 6'(ROUNDS - 1)) n_state = ST_WBACK;
            ST_WBACK: if (r_rd_v && r_rd_idx == 3'd7) n_state = ST_COLLECT;
            default:  n_state = ST_COLLECT;
        endcase
    end

    // outputs of the controller and datapath updates
    always_comb begin
        o_stall     = (r_state != ST_COLLECT);
        n_wcnt      = r_wcnt;
        n_cnt       = r_cnt;
        n_iv_sel    = r_iv_sel;
        n_out_valid = r_out_valid && !out_xfer;
        rd_en       = 1'b0;
        ram_we      = 1'b0;
        wb_word     = hash_word;
        n_v         = r_v;
        n_w         = r_w;
        unique case (r_state)
            ST_COLLECT: begin
                if (in_xfer) begin
                    for (int i = 0; i < BLOCK_N - 1; i++) n_w[i] = r_w[i+1];
                    n_w[BLOCK_N-1] = i_message_word;
                    if (i_start_message) begin
                        n_iv_sel = 1'b1;
                        n_wcnt   = 4'd1;
                    end else begin
                        n_wcnt = r_wcnt + 4'd1;
                    end
                end
                n_cnt = '0;
            end
            ST_LOAD: begin
                rd_en = !r_out_valid && r_cnt < 6'd8;
                if (rd_en) n_cnt = r_cnt + 6'd1;
                if (r_rd_v) begin
                    for (int i = 0; i < HASH_N - 1; i++) n_v[i] = r_v[i+1];
                    n_v[HASH_N-1] = hash_word;
                end
                if (r_rd_v && r_rd_idx == 3'd7) n_cnt = '0;
            end
            ST_ROUND: begin
                n_v[7] = r_v[6];
                n_v[6] = r_v[5];
                n_v[5] = r_v[4];
                n_v[4] = r_v[3] + t1;
                n_v[3] = r_v[2];
                n_v[2] = r_v[1];
                n_v[1] = r_v[0];
                n_v[0] = t1 + t2;
                for (int i = 0; i < BLOCK_N - 1; i++) n_w[i] = r_w[i+1];
                n_w[BLOCK_N-1] = w_new;
                n_cnt = (r_cnt == 6'(ROUNDS - 1)) ? '0 : r_cnt + 6'd1;
            end
            ST_WBACK: begin
                rd_en = r_cnt < 6'd8;
                if (rd_en) n_cnt = r_cnt + 6'd1;
                if (r_rd_v) begin
                    ram_we  = 1'b1;
                    wb_word = sum_word;
                    for (int i = 0; i < HASH_N - 1; i++) n_v[i] = r_v[i+1];
                    n_v[HASH_N-1] = wb_word;
                end
                if (r_rd_v && r_rd_idx == 3'd7) begin
                    n_out_valid = 1'b1;
                    n_iv_sel    = 1'b0;
                    n_wcnt      = '0;
                end
            end
            default: ;
        endcase
        if (r_state == ST_COLLECT && in_xfer && n_wcnt == 4'd0) n_wcnt = '0;
    end

    assign ram_raddr = r_cnt[2:0];

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_COLLECT;
            r_wcnt      <= '0;
            r_cnt       <= '0;
            r_iv_sel    <= 1'b1;
            r_out_valid <= 1'b0;
            r_rd_v      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wcnt      <= n_wcnt;
            r_cnt       <= n_cnt;
            r_iv_sel    <= n_iv_sel;
            r_out_valid <= n_out_valid;
            r_rd_v      <= rd_en;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= ram_raddr;
        r_v      <= n_v;
        r_w      <= n_w;
    end

    assign o_valid        = r_out_valid;
    assign o_digest_word0 = r_v[0];
    assign o_digest_word1 = r_v[1];
    assign o_digest_word2 = r_v[2];
    assign o_digest_word3 = r_v[3];
    assign o_digest_word4 = r_v[4];
    assign o_digest_word5 = r_v[5];
    assign o_digest_word6 = r_v[6];
    assign o_digest_word7 = r_v[7];

`ifndef SYNTHESIS
    a_we_only_wback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> r_state == ST_WBACK)
        else $error("hash memory written outside write-back");
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_cnt == 6'(ROUNDS - 1)) |=> r_state == ST_WBACK)
        else $error("round loop did not end after the last round");
    a_digest_after_wback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_WBACK))
        else $error("digest raised outside write-back");
    a_no_load_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD && r_out_valid) |-> !rd_en)
        else $error("state read started while digest pending");
`endif

endmodule
`default_nettype wire
